[design/wis_pkg.sv]
// Shared types and constants for the windowed interval statistics unit.
package wis_pkg;

    localparam int WINDOW_BITS = 48;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 48'd1000000000;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

endpackage

[design/windowed_interval_statistics_unit.sv]
// Windowed interval statistics: count, sum, min, max and mean over a time window.
// A zero or negative interval is dropped on acceptance; the block is ready again at once.
// A positive interval passes through accept, update of count, saturating sum and min/max,
// and window compare; when the sum reaches window_length it goes on to the mean, computed
// by the serial divider that produces one quotient bit a cycle. A finished summary waits
// in the output register while the next interval is taken; only a second summary stalls
// behind it. window_length resets to one second in nanoseconds.
module windowed_interval_statistics_unit #(
    parameter int INTERVAL_BITS = 40,
    parameter int COUNT_BITS    = 32,
    parameter int SUM_BITS      = 48
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [wis_pkg::WINDOW_BITS-1:0]        cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // interval_ns
    input  logic [((INTERVAL_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // sample_count, total_duration, shortest_interval, longest_interval, mean_interval
    output logic [((COUNT_BITS+2*SUM_BITS+2*(INTERVAL_BITS-1)+7)/8)*8-1:0] m_tdata
);
    import wis_pkg::*;

    localparam int MAG_BITS  = INTERVAL_BITS - 1;
    localparam int OUT_W     = COUNT_BITS + 2 * SUM_BITS + 2 * MAG_BITS;
    localparam int M_W       = ((OUT_W + 7) / 8) * 8;
    localparam int ADD_W     = (SUM_BITS > MAG_BITS ? SUM_BITS : MAG_BITS) + 1;
    localparam int CMP_W     = SUM_BITS > WINDOW_BITS ? SUM_BITS : WINDOW_BITS;

    state_t                   state_reg, state_next;
    logic [WINDOW_BITS-1:0]   window_reg;
    logic [MAG_BITS-1:0]      raw_reg;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [MAG_BITS-1:0]      min_reg, min_next;
    logic [MAG_BITS-1:0]      max_reg, max_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]         out_reg, out_next;

    logic                     in_take;
    logic                     in_positive;
    logic [ADD_W-1:0]         sum_ext;
    logic                     first;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_BITS-1:0]      div_quo;
    logic                     out_free;

    wis_div #(
        .DIVIDEND_BITS(SUM_BITS),
        .DIVISOR_BITS (COUNT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(sum_reg),
        .divisor (count_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_take     = s_tvalid && s_tready;
    assign in_positive = !s_tdata[INTERVAL_BITS-1] && (s_tdata[MAG_BITS-1:0] != '0);
    assign out_free    = !m_valid_reg || m_tready;
    assign first       = (count_reg == '0);
    assign sum_ext     = ADD_W'(sum_reg) + ADD_W'(raw_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take && in_positive) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (first || raw_reg < min_reg) begin
                    min_next = raw_reg;
                end
                if (first || raw_reg > max_reg) begin
                    max_next = raw_reg;
                end
                if (count_reg != '1) begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
                if (sum_ext > ADD_W'({SUM_BITS{1'b1}})) begin
                    sum_next = '1;
                end else begin
                    sum_next = sum_ext[SUM_BITS-1:0];
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (CMP_W'(sum_reg) >= CMP_W'(window_reg)) begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_next     = {div_quo, max_reg, min_reg, sum_reg, count_reg};
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    sum_next     = '0;
                    min_next     = '0;
                    max_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            count_reg   <= '0;
            sum_reg     <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (in_take) begin
            raw_reg <= s_tdata[MAG_BITS-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'(out_reg);

endmodule

[design/wis_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module wis_div #(
    parameter int DIVIDEND_BITS = 48,
    parameter int DIVISOR_BITS  = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits  = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/wis_checker.sv]
// Port-level checks for the windowed interval statistics unit, bound to the top level.
module wis_checker #(
    parameter int INTERVAL_BITS = 40,
    parameter int COUNT_BITS    = 32,
    parameter int SUM_BITS      = 48
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   cfg_wen,
    input logic [wis_pkg::WINDOW_BITS-1:0]        cfg_wdata,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((INTERVAL_BITS+7)/8)*8-1:0]     s_tdata,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((COUNT_BITS+2*SUM_BITS+2*(INTERVAL_BITS-1)+7)/8)*8-1:0] m_tdata
);
    localparam int MAG_BITS = INTERVAL_BITS - 1;
    localparam int O_SUM    = COUNT_BITS;
    localparam int O_MIN    = O_SUM + SUM_BITS;
    localparam int O_MAX    = O_MIN + MAG_BITS;
    localparam int O_MEAN   = O_MAX + MAG_BITS;

    logic [COUNT_BITS-1:0] f_count;
    logic [SUM_BITS-1:0]   f_sum;
    logic [MAG_BITS-1:0]   f_min;
    logic [MAG_BITS-1:0]   f_max;
    logic [SUM_BITS-1:0]   f_mean;
    logic                  pos_request;

    assign f_count     = m_tdata[O_SUM-1:0];
    assign f_sum       = m_tdata[O_MIN-1:O_SUM];
    assign f_min       = m_tdata[O_MAX-1:O_MIN];
    assign f_max       = m_tdata[O_MEAN-1:O_MAX];
    assign f_mean      = m_tdata[O_MEAN+SUM_BITS-1:O_MEAN];
    assign pos_request = s_tvalid && s_tready && !s_tdata[INTERVAL_BITS-1]
                         && (s_tdata[MAG_BITS-1:0] != '0);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("summary changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_request |=> !s_tready)
        else $error("ready stayed high after a positive interval");

    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("summary appeared without work in progress");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> f_count != '0 && f_min != '0 && f_min <= f_max && f_mean <= f_sum)
        else $error("summary fields inconsistent");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("summary valid after reset");

endmodule

bind windowed_interval_statistics_unit wis_checker #(
    .INTERVAL_BITS(INTERVAL_BITS),
    .COUNT_BITS   (COUNT_BITS),
    .SUM_BITS     (SUM_BITS)
) u_wis_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for the windowed interval statistics unit.
module tb;

    import wis_pkg::*;

    localparam int INTERVAL_BITS = 40;
    localparam int COUNT_BITS    = 32;
    localparam int SUM_BITS      = 48;
    localparam int IN_W          = ((INTERVAL_BITS + 7) / 8) * 8;
    localparam int OUT_W         = ((COUNT_BITS + 2 * SUM_BITS + 2 * (INTERVAL_BITS - 1) + 7) / 8) * 8;
    localparam int CNT_LO        = 0;
    localparam int SUM_LO        = CNT_LO + COUNT_BITS;
    localparam int MIN_LO        = SUM_LO + SUM_BITS;
    localparam int MAX_LO        = MIN_LO + INTERVAL_BITS - 1;
    localparam int MEAN_LO       = MAX_LO + INTERVAL_BITS - 1;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam logic [INTERVAL_BITS-1:0] LONGEST = {1'b0, {(INTERVAL_BITS-1){1'b1}}};

    typedef struct packed {
        logic [COUNT_BITS-1:0]    sample_count;
        logic [SUM_BITS-1:0]      total_duration;
        logic [INTERVAL_BITS-2:0] shortest_interval;
        logic [INTERVAL_BITS-2:0] longest_interval;
        logic [SUM_BITS-1:0]      mean_interval;
    } summary_t;

    typedef enum logic {ROW_WINDOW, ROW_INTERVAL} row_kind_t;
    typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_SUMMARY} outcome_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [63:0]      value;
        outcome_t         outcome;
        summary_t         summary;
    } row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [WINDOW_BITS-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    // predictor state
    logic [WINDOW_BITS-1:0]   window_ns;
    logic [COUNT_BITS-1:0]    acc_count;
    logic [SUM_BITS-1:0]      acc_sum;
    logic [INTERVAL_BITS-1:0] acc_min;
    logic [INTERVAL_BITS-1:0] acc_max;

    summary_t summaries_due[$];
    row_t     script[$];

    bit idle_in  = 1'b1;
    bit stall_on = 1'b1;
    int ready_hold;
    int cycle_count;
    int error_count;
    int items_sent;
    int ignored_sent;
    int summaries_seen;
    int windows_set;

    windowed_interval_statistics_unit #(
        .INTERVAL_BITS(INTERVAL_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .SUM_BITS     (SUM_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic fold_interval(input logic [INTERVAL_BITS-1:0] raw, output bit fired,
                                 output summary_t s);
        logic [SUM_BITS:0] wide;
        fired = 1'b0;
        s = '0;
        if (!raw[INTERVAL_BITS-1] && raw != '0) begin
            if (acc_count == '0) begin
                acc_min = raw;
                acc_max = raw;
            end else begin
                if (raw < acc_min) acc_min = raw;
                if (raw > acc_max) acc_max = raw;
            end
            if (acc_count != '1) acc_count = acc_count + COUNT_BITS'(1);
            wide = {1'b0, acc_sum} + (SUM_BITS+1)'(raw);
            acc_sum = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
            if (acc_sum >= window_ns) begin
                fired = 1'b1;
                s.sample_count      = acc_count;
                s.total_duration    = acc_sum;
                s.shortest_interval = acc_min[INTERVAL_BITS-2:0];
                s.longest_interval  = acc_max[INTERVAL_BITS-2:0];
                s.mean_interval     = acc_sum / SUM_BITS'(acc_count);
                acc_count = '0;
                acc_sum   = '0;
                acc_min   = '0;
                acc_max   = '0;
            end
        end
    endtask

    task automatic send_interval(input logic [INTERVAL_BITS-1:0] v, input outcome_t o,
                                 input summary_t typed);
        int gap;
        int r;
        bit fired;
        summary_t s;
        gap = 0;
        if (idle_in) begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(10, 60);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_interval(v, fired, s);
        if (!v[INTERVAL_BITS-1] && v != '0)
            items_sent++;
        else
            ignored_sent++;
        if (o == OUT_SUMMARY)
            summaries_due.push_back(typed);
        else if (o == OUT_MODEL && fired)
            summaries_due.push_back(s);
    endtask

    // drop valid, wait for every summary and let the datapath settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (summaries_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WINDOW_BITS-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        window_ns = v;
        windows_set++;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic add_row(input row_kind_t k, input logic [63:0] v, input outcome_t o,
                           input logic [COUNT_BITS-1:0] c, input logic [SUM_BITS-1:0] sm,
                           input logic [INTERVAL_BITS-2:0] lo, input logic [INTERVAL_BITS-2:0] hi,
                           input logic [SUM_BITS-1:0] mean);
        row_t r;
        r.kind    = k;
        r.value   = v;
        r.outcome = o;
        r.summary = '{sample_count: c, total_duration: sm, shortest_interval: lo,
                      longest_interval: hi, mean_interval: mean};
        script.push_back(r);
    endtask

    // result channel back-pressure
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (stall_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                       : $urandom_range(1, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        summary_t got;
        summary_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.sample_count      = m_tdata[CNT_LO +: COUNT_BITS];
            got.total_duration    = m_tdata[SUM_LO +: SUM_BITS];
            got.shortest_interval = m_tdata[MIN_LO +: INTERVAL_BITS-1];
            got.longest_interval  = m_tdata[MAX_LO +: INTERVAL_BITS-1];
            got.mean_interval     = m_tdata[MEAN_LO +: SUM_BITS];
            summaries_seen++;
            if (summaries_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("tb: unexpected summary count=%0d sum=%0d min=%0d max=%0d mean=%0d",
                             got.sample_count, got.total_duration, got.shortest_interval,
                             got.longest_interval, got.mean_interval);
            end else begin
                want = summaries_due.pop_front();
                if (got.sample_count !== want.sample_count
                        || got.total_duration !== want.total_duration
                        || got.shortest_interval !== want.shortest_interval
                        || got.longest_interval !== want.longest_interval
                        || got.mean_interval !== want.mean_interval) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("tb: mismatch at cycle %0d", cycle_count);
                        $display("  exp count=%0d sum=%0d min=%0d max=%0d mean=%0d",
                                 want.sample_count, want.total_duration, want.shortest_interval,
                                 want.longest_interval, want.mean_interval);
                        $display("  got count=%0d sum=%0d min=%0d max=%0d mean=%0d",
                                 got.sample_count, got.total_duration, got.shortest_interval,
                                 got.longest_interval, got.mean_interval);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        logic [63:0]            target;
        logic [INTERVAL_BITS-1:0] v;
        logic [WINDOW_BITS-1:0] w;
        int span;
        int phase;
        int r;

        window_ns = WINDOW_RESET;
        acc_count = '0;
        acc_sum   = '0;
        acc_min   = '0;
        acc_max   = '0;

        add_row(ROW_INTERVAL, 64'h0,           OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'hFF_FFFF_FFFF, OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'h80_0000_0000, OUT_NONE, 0, 0, 0, 0, 0);
        // reset window is one second: these two land on it exactly
        add_row(ROW_INTERVAL, 64'd999999999,   OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd1, OUT_SUMMARY, 2, 1000000000, 1, 999999999, 500000000);
        add_row(ROW_WINDOW,   64'd0,           OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd1,           OUT_SUMMARY, 1, 1, 1, 1, 1);
        add_row(ROW_INTERVAL, 64'h7F_FFFF_FFFF, OUT_SUMMARY, 1, 48'h7F_FFFF_FFFF,
                39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF, 48'h7F_FFFF_FFFF);
        add_row(ROW_INTERVAL, 64'hFF_FFFF_FFFB, OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_WINDOW,   64'd1,           OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'h55_5555_5555, OUT_SUMMARY, 1, 48'h55_5555_5555,
                39'h55_5555_5555, 39'h55_5555_5555, 48'h55_5555_5555);
        add_row(ROW_INTERVAL, 64'h2A_AAAA_AAAA, OUT_SUMMARY, 1, 48'h2A_AAAA_AAAA,
                39'h2A_AAAA_AAAA, 39'h2A_AAAA_AAAA, 48'h2A_AAAA_AAAA);
        add_row(ROW_WINDOW,   64'd100,         OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd30,          OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd0,           OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd50,          OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd10,          OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd10,          OUT_SUMMARY, 4, 100, 10, 50, 25);
        add_row(ROW_INTERVAL, 64'd7,           OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd200,         OUT_SUMMARY, 2, 207, 7, 200, 103);
        add_row(ROW_WINDOW,   64'hFFFF_FFFF_FFFF, OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd1000,        OUT_NONE, 0, 0, 0, 0, 0);
        // partial sum carries over into a smaller window
        add_row(ROW_WINDOW,   64'd3,           OUT_NONE, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd1,           OUT_MODEL, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd1,           OUT_MODEL, 0, 0, 0, 0, 0);
        add_row(ROW_INTERVAL, 64'd2,           OUT_MODEL, 0, 0, 0, 0, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WINDOW) begin
                quiesce();
                write_window(script[i].value[WINDOW_BITS-1:0]);
            end else begin
                send_interval(script[i].value[INTERVAL_BITS-1:0], script[i].outcome,
                              script[i].summary);
            end
        end

        phase = 0;
        while (items_sent + ignored_sent < 1700) begin
            quiesce();
            idle_in  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            if (phase == 2) begin
                // drive the sum into saturation against the widest window
                write_window('1);
                repeat (520)
                    send_interval(LONGEST - INTERVAL_BITS'($urandom_range(0, 63)),
                                  OUT_MODEL, '0);
            end else begin
                case ($urandom_range(0, 7))
                    0: w = '0;
                    1: w = 1;
                    2: w = WINDOW_BITS'($urandom_range(2, 1000));
                    3: w = WINDOW_BITS'($urandom);
                    4: w = WINDOW_RESET;
                    5: w = WINDOW_BITS'(rand64());
                    6: w = '1;
                    default: w = WINDOW_BITS'($urandom_range(1000, 100000));
                endcase
                write_window(w);
                span = $urandom_range(30, 90);
                repeat (span) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        v = ($urandom_range(0, 2) == 0) ? '0
                                : {1'b1, (INTERVAL_BITS-1)'(rand64())};
                    end else if (r < 20) begin
                        v = INTERVAL_BITS'(rand64());
                    end else if (r < 25) begin
                        v = ($urandom_range(0, 1) == 0) ? 1 : LONGEST;
                    end else begin
                        target = 64'(window_ns) / 64'($urandom_range(1, 16));
                        if (target > LONGEST) target = LONGEST;
                        if (target == 0) target = 1;
                        v = INTERVAL_BITS'(target - (rand64() % (target / 2 + 1)));
                    end
                    send_interval(v, OUT_MODEL, '0);
                end
            end
            phase++;
        end

        quiesce();
        if (summaries_due.size() != 0) error_count++;

        $display("tb: %0d intervals sent, %0d ignored, across %0d window settings",
                 items_sent, ignored_sent, windows_set);
        $display("tb: %0d summaries received, %0d errors", summaries_seen, error_count);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
